/* design/assert_macros.svh */
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared codes and field widths of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

   localparam int MODE_W   = 1;
   localparam int SIZE_W   = 11;
   localparam int ADDR_W   = 10;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SEEK,
      CS_PASS,
      CS_FLUSH,
      CS_DONE
   } ctrl_state_type;

endpackage

`default_nettype wire

/* design/ffsa_if.sv */
// ----------------------------------------------------------------------------
// ffsa_if
// Request and response channels of the allocator (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface ffsa_req_if import ffsa_pkg::*; ();
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [SIZE_W-1:0]   req_size;
   logic [ADDR_W-1:0]   free_addr;

   modport source (output valid, mode, req_size, free_addr, input ready);
   modport sink   (input valid, mode, req_size, free_addr, output ready);
endinterface

interface ffsa_rsp_if import ffsa_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [ADDR_W-1:0]   alloc_addr;

   modport source (output valid, status, alloc_addr, input ready);
   modport sink   (input valid, status, alloc_addr, output ready);
endinterface

`default_nettype wire

/* design/ffsa_cell.sv */
// ----------------------------------------------------------------------------
// ffsa_cell
// One slot of the segment ring: holds a segment entry, takes its neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_cell #(
   parameter int           W    = 8,
   parameter logic [W-1:0] INIT = '0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         shift,
   input  wire logic [W-1:0] nbr_data,
   output logic      [W-1:0] seg_out
);

   logic [W-1:0] seg_ff, seg_in;

   always_comb begin
      seg_in = shift ? nbr_data : seg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= INIT;
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign seg_out = seg_ff;

endmodule

`default_nettype wire

/* design/ffsa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Edit stage of the segment ring: first-fit search, split, free and merge.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ffsa_ctrl import ffsa_pkg::*; #(
   parameter int REGION_UNITS = 1024,
   parameter int MAX_SEGMENTS = 64,
   parameter int AW           = $clog2(REGION_UNITS),
   parameter int LW           = $clog2(REGION_UNITS + 1),
   parameter int EW           = 2 + AW + LW
) (
   input  wire logic          clock,
   input  wire logic          reset,
   ffsa_req_if.sink           req_chan,
   ffsa_rsp_if.source         rsp_chan,
   input  wire logic [EW-1:0] head,
   output logic      [EW-1:0] tail,
   output logic               shift
);

   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int SCW  = (LW > SIZE_W) ? LW : SIZE_W;
   localparam int CMPW = (AW > ADDR_W) ? AW : ADDR_W;

   typedef struct packed {
      logic          valid;
      logic          used;
      logic [AW-1:0] start;
      logic [LW-1:0] len;
   } seg_type;

   ctrl_state_type    state_ff, state_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [CNTW-1:0]   count_ff, count_in;
   seg_type           p_ff, p_in;
   seg_type           r_ff, r_in;
   logic              found_ff, found_in;
   mode_type          mode_ff, mode_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   seg_type head_s, e, e_mod, extra, merged;
   logic    op_en, merge_en, merge, split, at_zero;

   always_comb begin
      head_s  = seg_type'(head);
      at_zero = head_s.valid && (head_s.start == '0);
      e       = r_ff.valid ? r_ff : head_s;
      e_mod   = e;
      extra   = '0;
      split   = 1'b0;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      op_en    = (state_ff == CS_PASS) && !found_ff;
      merge_en = (state_ff == CS_PASS) || (state_ff == CS_FLUSH);

      if (op_en && e.valid) begin
         if (mode_ff == MODE_ALLOC) begin
            if (!e.used && (SCW'(e.len) >= SCW'(size_ff))) begin
               found_in = 1'b1;
               if (SCW'(e.len) > SCW'(size_ff)) begin
                  if (count_ff == CNTW'(MAX_SEGMENTS)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     // split: used head part here, free remainder rides in r_ff
                     split         = 1'b1;
                     e_mod.used    = 1'b1;
                     e_mod.len     = LW'(size_ff);
                     extra.valid   = 1'b1;
                     extra.used    = 1'b0;
                     extra.start   = e.start + AW'(size_ff);
                     extra.len     = e.len - LW'(size_ff);
                     res_status_in = STAT_OK;
                     res_addr_in   = ADDR_W'(e.start);
                  end
               end else begin
                  e_mod.used    = 1'b1;
                  res_status_in = STAT_OK;
                  res_addr_in   = ADDR_W'(e.start);
               end
            end
         end else if (CMPW'(e.start) == CMPW'(faddr_ff)) begin
            found_in      = 1'b1;
            e_mod.used    = 1'b0;
            res_status_in = STAT_OK;
         end
      end

      merged     = p_ff;
      merged.len = p_ff.len + e_mod.len;
      merge = merge_en && p_ff.valid && e_mod.valid && !p_ff.used && !e_mod.used &&
              ((LW'(p_ff.start) + p_ff.len) == LW'(e_mod.start));
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      count_in      = count_ff;
      p_in          = p_ff;
      r_in          = r_ff;
      mode_in       = mode_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      shift         = 1'b0;
      tail          = EW'(p_ff);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         CS_IDLE: begin
            if (req_chan.valid) begin
               mode_in  = req_chan.mode;
               size_in  = req_chan.req_size;
               faddr_in = req_chan.free_addr;
               state_in = CS_SEEK;
            end
         end
         CS_SEEK: begin
            if (at_zero) begin
               cnt_in   = '0;
               state_in = CS_PASS;
            end else begin
               shift = 1'b1;
               p_in  = head_s;
            end
         end
         CS_PASS, CS_FLUSH: begin
            if ((state_ff == CS_PASS) || r_ff.valid) begin
               shift    = 1'b1;
               // hold the last segment across empty slots so neighbors stay adjacent
               tail     = (merge || !e_mod.valid) ? '0 : EW'(p_ff);
               p_in     = merge ? merged : (e_mod.valid ? e_mod : p_ff);
               r_in     = split ? extra : (r_ff.valid ? head_s : seg_type'('0));
               count_in = count_ff + CNTW'(split) - CNTW'(merge);
               cnt_in   = cnt_ff + CNTW'(1);
               if ((state_ff == CS_PASS) && (cnt_ff == CNTW'(MAX_SEGMENTS))) begin
                  state_in = r_in.valid ? CS_FLUSH : CS_DONE;
               end
            end else begin
               state_in = CS_DONE;
            end
         end
         CS_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CS_IDLE;
         count_ff      <= CNTW'(1);
         p_ff          <= '0;
         r_ff          <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= STAT_MISS;
         res_addr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         p_ff         <= p_in;
         r_ff         <= r_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == CS_IDLE) begin
            // a zero-size allocate never matches
            found_ff      <= (req_chan.mode == MODE_ALLOC) && (req_chan.req_size == '0);
            res_status_ff <= STAT_MISS;
            res_addr_ff   <= '0;
         end else begin
            found_ff      <= found_in;
            res_status_ff <= res_status_in;
            res_addr_ff   <= res_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      faddr_ff      <= faddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign req_chan.ready      = (state_ff == CS_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.alloc_addr = rsp_addr_ff;

   `ASSERT_ALWAYS(a_count_range, clock, reset, (count_ff != '0) && (count_ff <= CNTW'(MAX_SEGMENTS)), "segment count out of range")
   `ASSERT_IMPLIES(a_carry_alloc, clock, reset, r_ff.valid, mode_ff == MODE_ALLOC, "carried segment outside allocate")
   `ASSERT_IMPLIES(a_done_clean, clock, reset, state_ff == CS_DONE, !r_ff.valid, "carried segment left at end of pass")
   `ASSERT_IMPLIES(a_split_room, clock, reset, shift && split, count_ff < CNTW'(MAX_SEGMENTS), "split with full table")

endmodule

`default_nettype wire

/* design/first_fit_segment_allocator.sv */
// An item (allocate or free) is handled one at a time. The segment table sits in a
// ring of MAX_SEGMENTS cells plus one edit register; after acceptance the ring rotates
// until the segment at address 0 reaches the head, then makes one full turn through
// the edit stage, where the first fit is found, split, freed and merged. A split
// carries the following entries one slot back until a free slot takes them. The
// result is then registered and the allocator returns to idle for the next item,
// once the response channel can take the result. A new item is taken while the
// previous result still waits on the response channel.
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit segment allocator with coalescing, built as a rotating cell ring.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator import ffsa_pkg::*; #(
   parameter int REGION_UNITS = 1024,
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ffsa_req_if.sink    req_chan,
   ffsa_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(REGION_UNITS);
   localparam int LW = $clog2(REGION_UNITS + 1);
   localparam int EW = 2 + AW + LW;
   // valid, free, start 0, whole region
   localparam logic [EW-1:0] SEG0 = {1'b1, 1'b0, AW'(0), LW'(REGION_UNITS)};

   logic [EW-1:0] cell_q [MAX_SEGMENTS];
   logic [EW-1:0] tail;
   logic          shift;

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      localparam logic [EW-1:0] RST = (i == 0) ? SEG0 : '0;
      logic [EW-1:0] nbr;
      if (i == MAX_SEGMENTS - 1) begin : g_last
         assign nbr = tail;
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      ffsa_cell #(.W(EW), .INIT(RST)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .nbr_data (nbr),
         .seg_out  (cell_q[i])
      );
   end

   ffsa_ctrl #(
      .REGION_UNITS (REGION_UNITS),
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .AW           (AW),
      .LW           (LW),
      .EW           (EW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .head     (cell_q[0]),
      .tail     (tail),
      .shift    (shift)
   );

endmodule

`default_nettype wire

/* dv/tb_first_fit_segment_allocator.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_segment_allocator
// Drives allocate and free requests into the allocator, keeps its own copy of
// the segment table to predict every response, and checks each response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_segment_allocator;
   import ffsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REGION  = 1024;
   localparam int MAX_SEG = 64;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] addr;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffsa_req_if req_chan ();
   ffsa_rsp_if rsp_chan ();

   first_fit_segment_allocator #(.REGION_UNITS(REGION), .MAX_SEGMENTS(MAX_SEG)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // segment table copy
   int unsigned tbl_start [MAX_SEG];
   int unsigned tbl_len   [MAX_SEG];
   bit          tbl_used  [MAX_SEG];
   int unsigned tbl_count;

   grant_type   grants_due [$];
   int          mismatches;
   int          responses;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;
   int unsigned n_alloc, n_free, n_full, n_miss;

   function automatic void table_clear();
      for (int i = 0; i < MAX_SEG; i++) begin
         tbl_start[i] = 0;
         tbl_len[i]   = 0;
         tbl_used[i]  = 1'b0;
      end
      tbl_len[0] = REGION;
      tbl_count  = 1;
   endfunction

   function automatic void table_remove(int unsigned idx);
      for (int unsigned i = idx; i + 1 < tbl_count; i++) begin
         tbl_start[i] = tbl_start[i+1];
         tbl_len[i]   = tbl_len[i+1];
         tbl_used[i]  = tbl_used[i+1];
      end
      tbl_count--;
   endfunction

   function automatic grant_type predict_grant(mode_type mode, int unsigned size,
                                               int unsigned faddr);
      grant_type   g;
      int unsigned i;
      g.status = STAT_OK;
      g.addr   = '0;
      if (mode == MODE_ALLOC) begin
         if (size == 0) begin
            g.status = STAT_MISS;
            return g;
         end
         for (i = 0; i < tbl_count; i++)
            if (!tbl_used[i] && tbl_len[i] >= size) break;
         if (i >= tbl_count) begin
            g.status = STAT_MISS;
            return g;
         end
         if (tbl_len[i] > size) begin
            if (tbl_count >= MAX_SEG) begin
               g.status = STAT_FULL;
               return g;
            end
            for (int unsigned j = tbl_count; j > i + 1; j--) begin
               tbl_start[j] = tbl_start[j-1];
               tbl_len[j]   = tbl_len[j-1];
               tbl_used[j]  = tbl_used[j-1];
            end
            tbl_start[i+1] = tbl_start[i] + size;
            tbl_len[i+1]   = tbl_len[i] - size;
            tbl_used[i+1]  = 1'b0;
            tbl_len[i]     = size;
            tbl_count++;
         end
         tbl_used[i] = 1'b1;
         g.addr = tbl_start[i][ADDR_W-1:0];
      end else begin
         for (i = 0; i < tbl_count; i++)
            if (tbl_start[i] == faddr) break;
         if (i >= tbl_count) begin
            g.status = STAT_MISS;
            return g;
         end
         tbl_used[i] = 1'b0;
         while (i + 1 < tbl_count && !tbl_used[i+1]) begin
            tbl_len[i] += tbl_len[i+1];
            table_remove(i + 1);
         end
         while (i > 0 && !tbl_used[i-1]) begin
            tbl_len[i-1] += tbl_len[i];
            table_remove(i);
            i--;
         end
      end
      return g;
   endfunction

   // pick the start of a segment that is currently allocated, or a random address
   function automatic int unsigned live_addr();
      int unsigned picks [$];
      for (int unsigned i = 0; i < tbl_count; i++)
         if (tbl_used[i]) picks.push_back(tbl_start[i]);
      if (picks.size() == 0) return $urandom_range(REGION - 1);
      return picks[$urandom_range(picks.size() - 1)];
   endfunction

   // valid stays up after acceptance until the next send or drain takes over
   task automatic send_item(mode_type mode, int unsigned size, int unsigned faddr);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= mode;
      req_chan.req_size  <= size[SIZE_W-1:0];
      req_chan.free_addr <= faddr[ADDR_W-1:0];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      grants_due.push_back(predict_grant(mode, size, faddr));
      if (mode == MODE_ALLOC) n_alloc++; else n_free++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (grants_due.size() != 0) @(negedge clock);
      repeat (3 * MAX_SEG + 10) @(negedge clock);
   endtask

   task automatic random_items(int count);
      int unsigned pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45)
            send_item(MODE_ALLOC, $urandom_range(64, 1), $urandom_range(REGION - 1));
         else if (pick < 52)
            send_item(MODE_ALLOC, $urandom_range(REGION, 1), $urandom_range(REGION - 1));
         else if (pick < 88)
            send_item(MODE_FREE, $urandom_range(2047), live_addr());
         else
            send_item(MODE_FREE, $urandom_range(2047), $urandom_range(REGION - 1));
      end
   endtask

   task automatic test_directed();
      send_item(MODE_ALLOC, REGION + 1, 0);      // oversize
      send_item(MODE_ALLOC, 2047, 1023);         // all size bits set
      send_item(MODE_ALLOC, 1, 1023);
      send_item(MODE_ALLOC, 3, 0);
      send_item(MODE_FREE, 0, 5);                // unknown address
      send_item(MODE_FREE, 2047, 0);
      send_item(MODE_FREE, 0, 0);                // already free, merge
      send_item(MODE_ALLOC, REGION, 0);          // whole region
      send_item(MODE_ALLOC, 1, 0);               // exact fit in the first free segment
      send_item(MODE_FREE, 0, 0);
      send_item(MODE_FREE, 0, 1023);
      // fill the table with unit segments, then hit the full case
      for (int i = 0; i < MAX_SEG - 1; i++) send_item(MODE_ALLOC, 1, 0);
      send_item(MODE_ALLOC, 5, 0);               // table full
      send_item(MODE_FREE, 0, 2);
      send_item(MODE_ALLOC, 1, 0);               // still full, no exact fit, refused
      drain();
      for (int i = 0; i < MAX_SEG; i++) send_item(MODE_FREE, 0, i);
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         random_items(20);
      join
      drain();
   endtask

   task automatic test_idle_phases();
      int pcts [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{27, 27}};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = pcts[p][0];
         recv_stall_pct = pcts[p][1];
         random_items(235);
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain();
   endtask

   // receiver stall, decided on the falling edge
   always @(negedge clock) begin
      if (reset || hold_off)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      grant_type exp_g;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         responses++;
         if (grants_due.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            exp_g = grants_due.pop_front();
            if (exp_g.status == STAT_FULL) n_full++;
            if (exp_g.status == STAT_MISS) n_miss++;
            if (rsp_chan.status !== exp_g.status) begin
               $error("status: expected %0d, got %0d", exp_g.status, rsp_chan.status);
               mismatches++;
            end
            if (rsp_chan.alloc_addr !== exp_g.addr) begin
               $error("alloc_addr: expected %0d, got %0d", exp_g.addr, rsp_chan.alloc_addr);
               mismatches++;
            end
         end
      end
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.mode      = MODE_ALLOC;
      req_chan.req_size  = '0;
      req_chan.free_addr = '0;
      rsp_chan.ready     = 1'b0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      responses = 0;
      cycle_count = 0;
      table_clear();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_idle_phases();
      drain();

      $display("covered %0d allocates, %0d frees, %0d responses", n_alloc, n_free, responses);
      $display("misses %0d, table-full refusals %0d", n_miss, n_full);
      if (mismatches == 0 && grants_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

/* first_fit_segment_allocator.f */
+incdir+design
design/ffsa_pkg.sv
design/ffsa_if.sv
design/ffsa_cell.sv
design/ffsa_ctrl.sv
design/first_fit_segment_allocator.sv
dv/tb_first_fit_segment_allocator.sv
